### rtl/tdrm_pkg.sv
// ----------------------------------------------------------------------------
// tdrm_pkg
// Types and constants shared by the tank drive ramp mixer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tdrm_pkg;

    localparam int IN_W  = 40;
    localparam int OUT_W = 24;
    localparam int CFG_W = 12;

    localparam int DIV_NUM_W = 22;
    localparam int DIV_DEN_W = 12;
    localparam int DIV_CNT_W = 5;

    localparam logic [DIV_CNT_W-1:0] COMP_DIV_STEPS = 5'd22;
    localparam logic [DIV_CNT_W-1:0] RAMP_DIV_STEPS = 5'd9;
    localparam logic [11:0]          COMP_MAX       = 12'd4095;
    localparam logic [7:0]           DUTY_MAX       = 8'd255;

    localparam logic [1:0] CFG_DEADZONE   = 2'd0;
    localparam logic [1:0] CFG_RAMP_DEN   = 2'd1;
    localparam logic [1:0] CFG_BATT_EMPTY = 2'd2;
    localparam logic [1:0] CFG_BATT_FULL  = 2'd3;

    localparam logic [8:0]  DEADZONE_RST   = 9'd30;
    localparam logic [7:0]  RAMP_DEN_RST   = 8'd20;
    localparam logic [11:0] BATT_EMPTY_RST = 12'd2381;
    localparam logic [11:0] BATT_FULL_RST  = 12'd2936;

    localparam logic [1:0] DIR_STOP = 2'd0;
    localparam logic [1:0] DIR_FWD  = 2'd1;
    localparam logic [1:0] DIR_REV  = 2'd2;

    typedef struct packed {
        logic [8:0]  deadzone;
        logic [7:0]  ramp_den;
        logic [11:0] batt_empty;
        logic [11:0] batt_full;
    } cfg_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
        logic [DIV_CNT_W-1:0] steps;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quot;
    } div_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TGT,
        ST_CDIV,
        ST_CWAIT,
        ST_LVL,
        ST_LDIV,
        ST_LWAIT,
        ST_RDIV,
        ST_RWAIT,
        ST_OUT,
        ST_EMIT_L,
        ST_EMIT_R
    } seq_state_t;

endpackage

`default_nettype wire

### rtl/tdrm_div.sv
// ----------------------------------------------------------------------------
// tdrm_div
// Shared restoring divider, one quotient bit per cycle. The numerator is
// left aligned; the request gives how many top bits to process.
// ----------------------------------------------------------------------------
`default_nettype none

module tdrm_div (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire tdrm_pkg::div_req_t req,
    output tdrm_pkg::div_rsp_t     rsp
);
    import tdrm_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_NUM_W-1:0] num_reg, num_next;
    logic [DIV_NUM_W-1:0] quot_reg, quot_next;
    logic [DIV_DEN_W-1:0] den_reg, den_next;
    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_DEN_W:0]   trial;
    logic                 ge;

    always_comb begin
        trial     = {rem_reg, num_reg[DIV_NUM_W-1]};
        ge        = trial >= {1'b0, den_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        quot_next = quot_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = req.steps;
            num_next  = req.num;
            den_next  = req.den;
            quot_next = '0;
            rem_next  = '0;
        end else if (busy_reg) begin
            rem_next  = ge ? DIV_DEN_W'(trial - {1'b0, den_reg}) : trial[DIV_DEN_W-1:0];
            quot_next = {quot_reg[DIV_NUM_W-2:0], ge};
            num_next  = {num_reg[DIV_NUM_W-2:0], 1'b0};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        num_reg  <= num_next;
        quot_reg <= quot_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

`default_nettype wire

### rtl/tdrm_seq.sv
// ----------------------------------------------------------------------------
// tdrm_seq
// Sequencer and datapath: targets, compensation divide, ramp divides,
// level update, compensated duty/direction and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tdrm_seq (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire tdrm_pkg::cfg_t                cfg,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [tdrm_pkg::IN_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [tdrm_pkg::OUT_W-1:0]         m_tdata
);
    import tdrm_pkg::*;

    seq_state_t state_reg, state_next;
    div_req_t   div_req;
    div_rsp_t   div_rsp;

    logic              conn_reg, turbo_reg;
    logic [9:0]        sy_reg, srx_reg;
    logic [11:0]       batt_reg;
    logic [11:0]       raw_reg;
    logic [11:0]       comp_reg;
    logic signed [8:0] lt_reg, rt_reg;
    logic signed [8:0] left_level_reg, right_level_reg;
    logic [7:0]        l_duty_reg, r_duty_reg;
    logic [1:0]        l_dir_reg, r_dir_reg;
    logic              m_valid_reg;

    function automatic logic signed [8:0] to_target(input logic signed [11:0] mix);
        logic [11:0] mag;
        logic [9:0]  cm;
        logic [17:0] p;
        logic [8:0]  t;
        mag = mix[11] ? 12'(-mix) : 12'(mix);
        cm  = (mag > 12'd512) ? 10'd512 : mag[9:0];
        p   = {cm, 8'b0} - 18'(cm);
        t   = {1'b0, p[16:9]};
        return mix[11] ? 9'(-$signed(t)) : $signed(t);
    endfunction

    // targets and battery clamp
    logic signed [10:0] fwd, turn, fwd_dz, turn_dz;
    logic [9:0]         fwd_mag, turn_mag;
    logic signed [11:0] mix_l, mix_r;
    logic [11:0]        raw_clamp;

    always_comb begin
        fwd      = 11'sd0 - $signed({sy_reg[9], sy_reg});
        turn     = $signed({srx_reg[9], srx_reg});
        fwd_mag  = fwd[10] ? 10'(-fwd) : fwd[9:0];
        turn_mag = turn[10] ? 10'(-turn) : turn[9:0];
        fwd_dz   = (fwd_mag < {1'b0, cfg.deadzone}) ? 11'sd0 : fwd;
        turn_dz  = (turn_mag < {1'b0, cfg.deadzone}) ? 11'sd0 : turn;
        mix_l    = {fwd_dz[10], fwd_dz} + {turn_dz[10], turn_dz};
        mix_r    = {fwd_dz[10], fwd_dz} - {turn_dz[10], turn_dz};
        if (batt_reg < cfg.batt_empty) begin
            raw_clamp = cfg.batt_empty;
        end else if (batt_reg > cfg.batt_full) begin
            raw_clamp = cfg.batt_full;
        end else begin
            raw_clamp = batt_reg;
        end
        if (raw_clamp == 12'd0) begin
            raw_clamp = 12'd1;
        end
    end

    // ramp path, shared by both motors
    logic              ramp_right;
    logic signed [8:0] cur_lvl, cur_tgt;
    logic signed [9:0] diff;
    logic [8:0]        diff_mag, q9, step;
    logic [7:0]        rs_eff;
    logic signed [10:0] lvl_ramp;

    always_comb begin
        ramp_right = (state_reg == ST_RDIV) || (state_reg == ST_RWAIT);
        cur_lvl    = ramp_right ? right_level_reg : left_level_reg;
        cur_tgt    = ramp_right ? rt_reg : lt_reg;
        diff       = {cur_tgt[8], cur_tgt} - {cur_lvl[8], cur_lvl};
        diff_mag   = diff[9] ? 9'(-diff) : diff[8:0];
        rs_eff     = (cfg.ramp_den == 8'd0) ? 8'd1 : cfg.ramp_den;
        q9         = div_rsp.quot[8:0];
        step       = ((q9 == 9'd0) && (diff != 10'sd0)) ? 9'd1 : q9;
        lvl_ramp   = diff[9] ? 11'({cur_lvl[8], cur_lvl[8], cur_lvl}) - 11'({2'b0, step})
                             : 11'({cur_lvl[8], cur_lvl[8], cur_lvl}) + 11'({2'b0, step});
    end

    // coast
    function automatic logic signed [8:0] coast(input logic signed [8:0] lvl);
        logic [7:0] mag;
        logic [9:0] m3;
        logic [8:0] r;
        mag = lvl[8] ? 8'(-lvl) : lvl[7:0];
        m3  = {mag, 1'b0} + 10'(mag);
        r   = {1'b0, m3[9:2]};
        return lvl[8] ? 9'(-$signed(r)) : $signed(r);
    endfunction

    // compensated output, shared multiplier
    logic signed [8:0] em_lvl;
    logic [7:0]        em_mag;
    logic [19:0]       em_prod;
    logic [9:0]        em_v;
    logic [7:0]        em_duty;
    logic [1:0]        em_dir;

    always_comb begin
        em_lvl  = (state_reg == ST_EMIT_R) ? right_level_reg : left_level_reg;
        em_mag  = em_lvl[8] ? 8'(-em_lvl) : em_lvl[7:0];
        em_prod = 20'(em_mag) * 20'(comp_reg);
        em_v    = em_prod[19:10];
        em_duty = (em_v > 10'(DUTY_MAX)) ? DUTY_MAX : em_v[7:0];
        if (em_duty == 8'd0) begin
            em_dir = DIR_STOP;
        end else if (em_lvl[8]) begin
            em_dir = DIR_REV;
        end else begin
            em_dir = DIR_FWD;
        end
    end

    // sequencer
    always_comb begin
        state_next    = state_reg;
        s_tready      = 1'b0;
        div_req.start = 1'b0;
        div_req.num   = {diff_mag, 13'b0};
        div_req.den   = {4'b0, rs_eff};
        div_req.steps = RAMP_DIV_STEPS;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    state_next = ST_TGT;
                end
            end
            ST_TGT: begin
                state_next = ST_CDIV;
            end
            ST_CDIV: begin
                div_req.start = 1'b1;
                div_req.num   = {cfg.batt_full, 10'b0};
                div_req.den   = raw_reg;
                div_req.steps = COMP_DIV_STEPS;
                state_next    = ST_CWAIT;
            end
            ST_CWAIT: begin
                if (div_rsp.done) begin
                    state_next = (conn_reg && !turbo_reg) ? ST_LDIV : ST_LVL;
                end
            end
            ST_LVL: begin
                state_next = ST_OUT;
            end
            ST_LDIV: begin
                div_req.start = 1'b1;
                state_next    = ST_LWAIT;
            end
            ST_LWAIT: begin
                if (div_rsp.done) begin
                    state_next = ST_RDIV;
                end
            end
            ST_RDIV: begin
                div_req.start = 1'b1;
                state_next    = ST_RWAIT;
            end
            ST_RWAIT: begin
                if (div_rsp.done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg) begin
                    state_next = ST_EMIT_L;
                end
            end
            ST_EMIT_L: begin
                state_next = ST_EMIT_R;
            end
            ST_EMIT_R: begin
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_level_reg  <= '0;
            right_level_reg <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_LVL: begin
                    if (conn_reg) begin
                        left_level_reg  <= lt_reg;
                        right_level_reg <= rt_reg;
                    end else begin
                        left_level_reg  <= coast(left_level_reg);
                        right_level_reg <= coast(right_level_reg);
                    end
                end
                ST_LWAIT: begin
                    if (div_rsp.done) begin
                        left_level_reg <= lvl_ramp[8:0];
                    end
                end
                ST_RWAIT: begin
                    if (div_rsp.done) begin
                        right_level_reg <= lvl_ramp[8:0];
                    end
                end
                ST_EMIT_R: begin
                    m_valid_reg <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_tvalid) begin
            conn_reg  <= s_tdata[0];
            sy_reg    <= s_tdata[10:1];
            srx_reg   <= s_tdata[20:11];
            turbo_reg <= s_tdata[21];
            batt_reg  <= s_tdata[33:22];
        end
        if (state_reg == ST_TGT) begin
            lt_reg  <= to_target(mix_l);
            rt_reg  <= to_target(mix_r);
            raw_reg <= raw_clamp;
        end
        if (state_reg == ST_CWAIT && div_rsp.done) begin
            comp_reg <= (div_rsp.quot > DIV_NUM_W'(COMP_MAX)) ? COMP_MAX : div_rsp.quot[11:0];
        end
        if (state_reg == ST_EMIT_L) begin
            l_duty_reg <= em_duty;
            l_dir_reg  <= em_dir;
        end
        if (state_reg == ST_EMIT_R) begin
            r_duty_reg <= em_duty;
            r_dir_reg  <= em_dir;
        end
    end

    tdrm_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0, r_dir_reg, r_duty_reg, l_dir_reg, l_duty_reg};

endmodule

`default_nettype wire

### rtl/tank_drive_ramp_mixer_top.sv
// ----------------------------------------------------------------------------
// tank_drive_ramp_mixer_top
// Tank drive mixer with slew-rate limited motor levels and battery
// compensated duty output.
// ----------------------------------------------------------------------------
// One request per control tick: stick axes are deadzoned, tank-mixed and
// scaled to +-255 targets; levels ramp toward them (turbo jumps, disconnect
// coasts by 3/4); each level is multiplied by full*1024/raw, shifted right
// by 10 and sent as duty and direction. Each result waits for the result
// register to drain. The one shared restoring divider runs 22 steps for the
// compensation factor and 9 steps for each motor's ramp step. The next
// request is taken while the previous result waits in the result register.
// Configuration is written through cfg_wr_en/cfg_addr/cfg_wdata; the user
// must write it only while idle, the block itself does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module tank_drive_ramp_mixer_top (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [1:0]                      cfg_addr,
    input  wire logic [tdrm_pkg::CFG_W-1:0]      cfg_wdata,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // connected[0], stick_y[10:1], stick_rx[20:11], turbo[21],
    // battery_sample[33:22], zero[39:34]
    input  wire logic [tdrm_pkg::IN_W-1:0]       s_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // left_duty[7:0], left_dir[9:8], right_duty[17:10], right_dir[19:18],
    // zero[23:20]
    output logic [tdrm_pkg::OUT_W-1:0]           m_tdata
);
    import tdrm_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.deadzone   <= DEADZONE_RST;
            cfg_reg.ramp_den   <= RAMP_DEN_RST;
            cfg_reg.batt_empty <= BATT_EMPTY_RST;
            cfg_reg.batt_full  <= BATT_FULL_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_DEADZONE:   cfg_reg.deadzone   <= cfg_wdata[8:0];
                CFG_RAMP_DEN:   cfg_reg.ramp_den   <= cfg_wdata[7:0];
                CFG_BATT_EMPTY: cfg_reg.batt_empty <= cfg_wdata;
                CFG_BATT_FULL:  cfg_reg.batt_full  <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    tdrm_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

### rtl/tdrm_chk.sv
// ----------------------------------------------------------------------------
// tdrm_chk
// Port-level checks for the tank drive ramp mixer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tdrm_chk (
    input wire logic                      aclk,
    input wire logic                      aresetn,
    input wire logic                      s_tvalid,
    input wire logic                      s_tready,
    input wire logic                      m_tvalid,
    input wire logic                      m_tready,
    input wire logic [tdrm_pkg::OUT_W-1:0] m_tdata
);
    import tdrm_pkg::*;

    // stop direction exactly when the duty is zero
    a_left_dir: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[7:0] == 8'd0) == (m_tdata[9:8] == DIR_STOP)))
        else $error("left direction disagrees with duty");

    a_right_dir: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[17:10] == 8'd0) == (m_tdata[19:18] == DIR_STOP)))
        else $error("right direction disagrees with duty");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request taken while previous one still in work");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind tank_drive_ramp_mixer_top tdrm_chk u_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
